@@ hw/rtl/stereo_feedback_delay_macros.svh @@
// ----------------------------------------------------------------------------
// Stereo feedback delay assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define SFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition holds at every clock edge outside reset.
`define SFD_ASSERT_ALWAYS(lbl, cond, msg) \
  `SFD_ASSERT_IMPL(lbl, 1'b1, cond, msg)

`endif

@@ hw/rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo feedback delay package
// Register codes, fixed field widths and the lane control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  // Feedback gain is unsigned Q0.15 and is clamped to 0.9 of unity.
  localparam int unsigned GAIN_W      = 15;
  localparam int unsigned GAIN_FRAC_W = 15;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 15'd29491;

  // Delay register width and its value after reset.
  localparam int unsigned DELAY_W     = 17;
  localparam int unsigned DELAY_RESET = 24000;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd2;

  // Result queue that decouples the pipeline from the output side.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  // Per-cycle control handed from the shared controller to each lane.
  typedef struct packed {
    logic fwd_c;   // read hits the write of the item in the last stage
    logic fwd_l;   // read hits the write committed in the previous cycle
    logic filled;  // read address has been written since reset
    logic en_c;    // item in the last stage has the delay applied
    logic wr_c;    // item in the last stage writes its ring entry
  } lane_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sfd_lane.sv @@
// ----------------------------------------------------------------------------
// Stereo feedback delay lane
// One channel: ring buffer, read forwarding, feedback multiply and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_lane #(
  parameter int RING_DEPTH  = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                               clk_i,
  input  wire sfd_pkg::lane_ctrl_t                ctrl_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0]      rd_addr_i,
  input  wire logic [$clog2(RING_DEPTH)-1:0]      wr_addr_i,
  input  wire logic [sfd_pkg::GAIN_W-1:0]         gain_i,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_i,
  output logic signed [SAMPLE_BITS-1:0]           result_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + sfd_pkg::GAIN_W + 1;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (sfd_pkg::GAIN_FRAC_W - 1);
  localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

  // Clamp a sum with two guard bits to the sample range.
  function automatic logic signed [SB-1:0] sat(input logic signed [SB+1:0] v);
    logic ovf;
    ovf = (v[SB+1] != v[SB-1]) || (v[SB] != v[SB-1]);
    if (ovf) begin
      return v[SB+1] ? SAT_MIN : SAT_MAX;
    end
    return v[SB-1:0];
  endfunction

  logic [SB-1:0]          ring_q [RING_DEPTH];
  logic signed [SB-1:0]   rdata_q;
  logic signed [SB-1:0]   s1_x_q;
  logic signed [SB-1:0]   s2_x_q;
  logic signed [SB-1:0]   s2_dly_q;
  logic signed [SB-1:0]   lw_data_q;
  logic signed [SB-1:0]   dly_b;
  logic signed [PW-1:0]   prod_c;
  logic signed [PW-1:0]   rnd_c;
  logic signed [SB:0]     scaled_c;
  logic signed [SB+1:0]   fb_sum_c;
  logic signed [SB+1:0]   out_sum_c;
  logic signed [SB-1:0]   wr_val_c;

  // Ring read for the item being accepted; the registered data is used in the middle stage.
  always_ff @(posedge clk_i) begin
    rdata_q <= ring_q[rd_addr_i];
  end

  // Ring write from the last stage.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_c) begin
      ring_q[wr_addr_i] <= wr_val_c;
    end
  end

  // Middle stage: pick the delayed sample, newest write first.
  always_comb begin
    if (ctrl_i.fwd_c) begin
      dly_b = wr_val_c;
    end else if (ctrl_i.fwd_l) begin
      dly_b = lw_data_q;
    end else if (ctrl_i.filled) begin
      dly_b = rdata_q;
    end else begin
      dly_b = '0;
    end
  end

  // Payload pipeline; validity is tracked by the controller.
  always_ff @(posedge clk_i) begin
    s1_x_q    <= sample_i;
    s2_x_q    <= s1_x_q;
    s2_dly_q  <= dly_b;
    lw_data_q <= wr_val_c;
  end

  // Last stage: feedback product rounded half up, then the saturated sums.
  assign prod_c    = s2_dly_q * $signed({1'b0, gain_i});
  assign rnd_c     = prod_c + RND_HALF;
  assign scaled_c  = rnd_c[PW-1:sfd_pkg::GAIN_FRAC_W];
  assign fb_sum_c  = {{2{s2_x_q[SB-1]}}, s2_x_q} + {scaled_c[SB], scaled_c};
  assign out_sum_c = {{2{s2_x_q[SB-1]}}, s2_x_q} + {{2{s2_dly_q[SB-1]}}, s2_dly_q};
  assign wr_val_c  = sat(fb_sum_c);
  assign result_o  = ctrl_i.en_c ? sat(out_sum_c) : s2_x_q;

endmodule

`default_nettype wire

@@ hw/rtl/stereo_feedback_delay.sv @@
// ----------------------------------------------------------------------------
// Stereo feedback delay
// Feedback comb filter on a stereo stream, one ring buffer lane per channel.
// ----------------------------------------------------------------------------
// The block takes one stereo pair per clock while the result queue has credit
// and no delay reduction is pending, and returns one pair per pair through a
// four-entry result queue. Both channels run in their own lane with one ring
// memory read and one write per cycle; a delay of one sample is carried by
// forwarding the write value of the last stage, so the multiply, round and
// saturate of that stage set the critical path. After a write to the delay
// register, the delay is brought modulo the ring depth by a reciprocal
// multiply at the write and a multiply-subtract in the next cycle; input
// transfers are held off until the subtract is done. The rings need no
// clearing pass: a fill mark reads never-written entries as zero.
`default_nettype none

`include "stereo_feedback_delay_macros.svh"

module stereo_feedback_delay #(
  parameter int RING_DEPTH  = 131072,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  // Configuration writes
  input  wire logic                                       cfg_we_i,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  wire logic [sfd_pkg::CFG_DATA_W-1:0]             cfg_wdata_i,
  // Input stream
  input  wire logic                                       s_axis_tvalid,
  output logic                                            s_axis_tready,
  // tdata: left_in, right_in, zero pad
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_axis_tdata,
  // Output stream
  output logic                                            m_axis_tvalid,
  input  wire logic                                       m_axis_tready,
  // tdata: left_out, right_out, zero pad
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]              m_axis_tdata
);

  localparam int SB      = SAMPLE_BITS;
  localparam int AW      = $clog2(RING_DEPTH);
  localparam int TDATA_W = ((2*SAMPLE_BITS+7)/8)*8;
  localparam int DW      = sfd_pkg::DELAY_W;
  localparam int MW      = DW + 2;
  localparam int PRW     = DW + MW;
  localparam int unsigned RECIP_SH = DW + AW;
  localparam longint unsigned RECIP_M = ((64'd1 << RECIP_SH) / RING_DEPTH) + 1;
  localparam logic [DW-1:0] DELAY_RST_MOD = DW'(sfd_pkg::DELAY_RESET % RING_DEPTH);
  localparam logic [AW-1:0] LAST_IDX      = AW'(RING_DEPTH - 1);

  // Configuration registers
  logic                           enable_q;
  logic [sfd_pkg::GAIN_W-1:0]     gain_q;
  logic [DW-1:0]                  dly_q;
  logic                           dly_busy_q;
  logic [DW-1:0]                  dly_raw_q;
  logic [DW-1:0]                  dly_quot_q;
  logic [PRW-1:0]                 dly_prod;
  logic [DW-1:0]                  dly_quot;
  logic [2*DW-1:0]                dly_back;

  // Pointer and pipeline control
  logic              s_accept;
  logic [AW-1:0]     w_q;
  logic              wrapped_q;
  logic [AW:0]       rd_diff;
  logic [AW:0]       rd_wrap;
  logic [AW-1:0]     rd_a;
  logic              filled_a;
  logic              s1_v_q, s1_en_q, s1_filled_q;
  logic [AW-1:0]     s1_rd_q, s1_w_q;
  logic              s2_v_q, s2_en_q;
  logic [AW-1:0]     s2_w_q;
  logic              lw_v_q;
  logic [AW-1:0]     lw_addr_q;
  sfd_pkg::lane_ctrl_t ctrl;

  // Result queue
  logic [2*SB-1:0]               fifo_q [sfd_pkg::FIFO_DEPTH];
  logic [sfd_pkg::FIFO_AW-1:0]   fifo_wptr_q, fifo_rptr_q;
  logic [sfd_pkg::FIFO_CW-1:0]   occ;
  logic [sfd_pkg::FIFO_CW-1:0]   fifo_cnt_q;
  logic                          push, pop;
  logic signed [SB-1:0]          left_res, right_res;

  // Delay modulo depth: quotient by reciprocal multiply, then subtract it back.
  assign dly_prod = PRW'(cfg_wdata_i[DW-1:0]) * PRW'(RECIP_M);
  assign dly_quot = DW'(dly_prod >> RECIP_SH);
  assign dly_back = (2*DW)'(dly_quot_q) * (2*DW)'(RING_DEPTH);

  // Configuration writes and delay reduction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      gain_q     <= '0;
      dly_q      <= DELAY_RST_MOD;
      dly_busy_q <= 1'b0;
      dly_raw_q  <= '0;
      dly_quot_q <= '0;
    end else begin
      dly_busy_q <= cfg_we_i && (cfg_idx_i == sfd_pkg::CFG_DELAY);
      if (dly_busy_q) begin
        dly_q <= dly_raw_q - dly_back[DW-1:0];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfd_pkg::CFG_ENABLE: begin
            enable_q <= cfg_wdata_i[0];
          end
          sfd_pkg::CFG_GAIN: begin
            gain_q <= (cfg_wdata_i[sfd_pkg::GAIN_W-1:0] > sfd_pkg::GAIN_MAX) ?
                      sfd_pkg::GAIN_MAX : cfg_wdata_i[sfd_pkg::GAIN_W-1:0];
          end
          sfd_pkg::CFG_DELAY: begin
            dly_raw_q  <= cfg_wdata_i[DW-1:0];
            dly_quot_q <= dly_quot;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Credit check: every item in flight has a queue slot waiting for it.
  assign occ = fifo_cnt_q + sfd_pkg::FIFO_CW'(s1_v_q) + sfd_pkg::FIFO_CW'(s2_v_q);
  assign s_axis_tready = !dly_busy_q && (occ < sfd_pkg::FIFO_CW'(sfd_pkg::FIFO_DEPTH));
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Read address and fill mark for the item being accepted.
  assign rd_diff  = {1'b0, w_q} - {1'b0, AW'(dly_q)};
  assign rd_wrap  = rd_diff + (AW+1)'(RING_DEPTH);
  assign rd_a     = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
  assign filled_a = wrapped_q || (rd_a < w_q);

  // Write pointer and pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= '0;
      wrapped_q <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      lw_v_q    <= 1'b0;
    end else begin
      if (s_accept && enable_q) begin
        if (w_q == LAST_IDX) begin
          w_q       <= '0;
          wrapped_q <= 1'b1;
        end else begin
          w_q <= w_q + 1'b1;
        end
      end
      s1_v_q <= s_accept;
      s2_v_q <= s1_v_q;
      lw_v_q <= s2_v_q && s2_en_q;
    end
  end

  // Pipeline addresses and flags
  always_ff @(posedge clk_i) begin
    s1_en_q     <= enable_q;
    s1_rd_q     <= rd_a;
    s1_w_q      <= w_q;
    s1_filled_q <= filled_a;
    s2_en_q     <= s1_en_q;
    s2_w_q      <= s1_w_q;
    lw_addr_q   <= s2_w_q;
  end

  // Forwarding decisions are shared by both lanes.
  assign ctrl.fwd_c  = s2_v_q && s2_en_q && (s2_w_q == s1_rd_q);
  assign ctrl.fwd_l  = lw_v_q && (lw_addr_q == s1_rd_q);
  assign ctrl.filled = s1_filled_q;
  assign ctrl.en_c   = s2_en_q;
  assign ctrl.wr_c   = s2_v_q && s2_en_q;

  sfd_lane #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_addr_i (rd_a),
    .wr_addr_i (s2_w_q),
    .gain_i    (gain_q),
    .sample_i  (s_axis_tdata[SB-1:0]),
    .result_o  (left_res)
  );

  sfd_lane #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_addr_i (rd_a),
    .wr_addr_i (s2_w_q),
    .gain_i    (gain_q),
    .sample_i  (s_axis_tdata[2*SB-1:SB]),
    .result_o  (right_res)
  );

  // Merge the lane results into the result queue.
  assign push = s2_v_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[fifo_wptr_q] <= {right_res, left_res};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wptr_q <= '0;
      fifo_rptr_q <= '0;
      fifo_cnt_q  <= '0;
    end else begin
      if (push) begin
        fifo_wptr_q <= fifo_wptr_q + 1'b1;
      end
      if (pop) begin
        fifo_rptr_q <= fifo_rptr_q + 1'b1;
      end
      if (push && !pop) begin
        fifo_cnt_q <= fifo_cnt_q + 1'b1;
      end else if (pop && !push) begin
        fifo_cnt_q <= fifo_cnt_q - 1'b1;
      end
    end
  end

  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = TDATA_W'(fifo_q[fifo_rptr_q]);

  // Checks
  `SFD_ASSERT_IMPL(a_no_transfer_busy, dly_busy_q, !s_axis_tready,
                   "input transfer taken during delay reduction")
  `SFD_ASSERT_ALWAYS(a_credit_bound, occ <= sfd_pkg::FIFO_CW'(sfd_pkg::FIFO_DEPTH),
                     "items in flight exceed result queue space")
  `SFD_ASSERT_IMPL(a_queue_no_overflow, push && !pop,
                   fifo_cnt_q < sfd_pkg::FIFO_CW'(sfd_pkg::FIFO_DEPTH),
                   "result queue overflow")
  `SFD_ASSERT_IMPL(a_fwd_only_filled, s1_v_q && !s1_filled_q, !(ctrl.fwd_c || ctrl.fwd_l),
                   "forward hit on a ring entry never written")

endmodule

`default_nettype wire
